// ===== design/upu_pkg.sv =====
// Shared types, character constants and phase codes for the URI percent unescaper.
// Used by upu_decode, upu_out_buf and uri_percent_unescaper_unit.
package upu_pkg;

    localparam logic [7:0] CH_QMARK   = 8'h3f;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [4:0] HEX_LETTER = 5'd10;

    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_QUOTED = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    localparam int MODE_URI_BIT      = 0;
    localparam int MODE_REDIRECT_BIT = 1;

    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       stop;
    } res_t;

endpackage

// ===== design/upu_decode.sv =====
// Per-byte decode step: phase, nibble and halt state plus the result group logic.
// Depends on upu_pkg for constants and the res_t result group.
module upu_decode
    import upu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] mode,
    input  logic [7:0] ch,
    input  logic       start,
    input  logic       advance,
    output res_t       res
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic [7:0] first_reg, first_next;
    logic       halted_reg, halted_next;

    logic [1:0] eff_phase;
    logic       eff_halt;
    logic       is_dec;
    logic       is_hex;
    logic [7:0] low_ch;
    logic [3:0] hv;
    logic [7:0] v;
    logic       safe;
    logic       uri_on;
    logic       redir_on;
    logic [7:0] dec_sum;
    logic [7:0] let_sum;

    always_comb
    begin
        uri_on    = mode[MODE_URI_BIT];
        redir_on  = mode[MODE_REDIRECT_BIT];
        eff_phase = start ? PH_PLAIN : phase_reg;
        eff_halt  = start ? 1'b0 : halted_reg;
        low_ch    = ch | CASE_BIT;
        is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
        dec_sum   = ch - CH_ZERO;
        let_sum   = low_ch - CH_LOW_A + {3'd0, HEX_LETTER};
        is_hex    = is_dec || ((low_ch >= CH_LOW_A) && (low_ch <= CH_LOW_F));
        hv        = is_dec ? dec_sum[3:0] : let_sum[3:0];
        v         = {nib_reg, hv};
        safe      = (v > CH_PCT) && (v < CH_DEL);

        phase_next  = eff_phase;
        nib_next    = nib_reg;
        first_next  = first_reg;
        halted_next = eff_halt;
        res.cnt     = 2'd0;
        res.b0      = ch;
        res.b1      = first_reg;
        res.b2      = ch;
        res.stop    = 1'b0;

        if (!eff_halt)
        begin
            unique case (eff_phase)
                PH_QUOTED:
                begin
                    if (is_hex)
                    begin
                        nib_next   = hv;
                        first_next = ch;
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        phase_next = PH_PLAIN;
                        res.cnt    = 2'd1;
                    end
                end
                PH_SECOND:
                begin
                    phase_next = PH_PLAIN;
                    res.b0     = v;
                    if (is_hex)
                    begin
                        res.cnt = 2'd1;
                        if (is_dec)
                        begin
                            if (redir_on && !safe)
                            begin
                                res.cnt = 2'd3;
                                res.b0  = CH_PCT;
                            end
                        end
                        else if (uri_on || redir_on)
                        begin
                            if (v == CH_QMARK)
                            begin
                                res.stop    = 1'b1;
                                halted_next = 1'b1;
                            end
                            else if (!uri_on && !safe)
                            begin
                                res.cnt = 2'd3;
                                res.b0  = CH_PCT;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                    if ((ch == CH_QMARK) && (uri_on || redir_on))
                    begin
                        res.cnt     = 2'd1;
                        res.stop    = 1'b1;
                        halted_next = 1'b1;
                    end
                    else if (ch == CH_PCT)
                    begin
                        phase_next = PH_QUOTED;
                    end
                    else
                    begin
                        res.cnt = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            nib_reg    <= 4'd0;
            first_reg  <= 8'd0;
            halted_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            nib_reg    <= nib_next;
            first_reg  <= first_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== design/upu_out_buf.sv =====
// Result buffer for one group of up to three bytes; sends one per cycle unless stalled.
// Depends on upu_pkg for the res_t result group.
module upu_out_buf
    import upu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       stop_hit,
    output logic       last_of_run
);

    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic       stop_reg;
    logic       fire;

    always_comb
    begin
        out_valid   = (cnt_reg != 2'd0);
        last_of_run = (cnt_reg == 2'd1);
        fire        = out_valid && !out_stall;
        can_load    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);
        out_byte    = b0_reg;
        stop_hit    = stop_reg;
        if (load)
        begin
            cnt_next = res.cnt;
        end
        else if (fire)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b0_reg   <= res.b0;
            b1_reg   <= res.b1;
            b2_reg   <= res.b2;
            stop_reg <= res.stop;
        end
        else if (fire)
        begin
            b0_reg <= b1_reg;
            b1_reg <= b2_reg;
        end
    end

endmodule

// ===== design/uri_percent_unescaper_unit.sv =====
// URI percent unescaper: one escaped byte in per item, zero to three decoded bytes out.
// Uses upu_pkg, upu_decode and upu_out_buf.
//
// Input channel: in_valid, in_stall, in_byte, start_string. An item is taken at a
// clock edge with in_valid high and in_stall low. start_string begins a new string.
// Output channel: out_valid, out_stall, out_byte, stop_hit, last_of_run. Each input
// item yields zero to three result items; last_of_run marks the final one.
// Configuration: APB-style port, register unescape_mode at byte address 0.
// The input item is held in the input register, and its first result item is shown
// once the group that the decode logic forms from it is loaded into the output buffer.
// Throughput is one item per cycle while every item gives at most one result and
// out_stall stays low; an item that is re-emitted as three characters holds the
// output buffer, which sets in_stall until the buffer can take a new group.
// An input register feeds the decode logic, whose group goes into the output
// buffer; the buffer takes a new group while its last byte is being taken.
// Reset clears the phase, halt flag, mode register and all valid flags.
// When out_stall is high the shown result holds, and in_stall rises once the
// input register is full behind it.
module uri_percent_unescaper_unit
    import upu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        start_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        stop_hit,
    output logic        last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] mode_reg;
    logic       iv_reg, iv_next;
    logic [7:0] ib_reg;
    logic       is_reg;
    logic       can_load;
    logic       advance;
    logic       accept;
    res_t       res;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MODE) ? {30'd0, mode_reg} : 32'd0;
    assign advance  = iv_reg && can_load;
    assign in_stall = iv_reg && !can_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            iv_next = 1'b1;
        end
        else if (advance)
        begin
            iv_next = 1'b0;
        end
        else
        begin
            iv_next = iv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'd0;
            iv_reg   <= 1'b0;
        end
        else
        begin
            iv_reg <= iv_next;
            if (psel && penable && pwrite && (paddr[2] == REG_MODE))
            begin
                mode_reg <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ib_reg <= in_byte;
            is_reg <= start_string;
        end
    end

    upu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .ch      (ib_reg),
        .start   (is_reg),
        .advance (advance),
        .res     (res)
    );

    upu_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .res         (res),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .stop_hit    (stop_hit),
        .last_of_run (last_of_run)
    );

endmodule

// ===== design/upu_checker.sv =====
// Port-level checks for uri_percent_unescaper_unit, attached by a bind statement.
// Depends on upu_pkg for the question mark constant.
module upu_checker
    import upu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       stop_hit,
    input logic       last_of_run,
    input logic       pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(last_of_run))
        else $error("Stalled output item changed.");

    a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_hit |-> last_of_run && (out_byte == CH_QMARK))
        else $error("Halting item is not a lone question mark.");

    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && !out_stall |=> out_valid)
        else $error("Run of result items broke off early.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("Configuration port not ready.");

endmodule

bind uri_percent_unescaper_unit upu_checker u_upu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .stop_hit    (stop_hit),
    .last_of_run (last_of_run),
    .pready      (pready)
);

// ===== tb/uri_percent_unescaper_unit_tb.sv =====
// Self-checking testbench for uri_percent_unescaper_unit: random bursts of escaped bytes
// under every unescape mode, checked against a decoder model kept in the testbench.
// Depends on upu_pkg and the uri_percent_unescaper_unit RTL.
module uri_percent_unescaper_unit_tb;
    import upu_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam logic [2:0] MODE_ADDR = {REG_MODE, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       fresh;
    } esc_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       stop;
        logic       last;
    } dec_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        start_string = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        stop_hit;
    logic        last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    esc_item_t escaped_bytes[$];
    dec_item_t decoded_bytes[$];

    logic [1:0] cfg_mode = 2'd0;
    logic [1:0] dec_phase = PH_PLAIN;
    logic [3:0] dec_high = 4'd0;
    logic [7:0] dec_first = 8'd0;
    logic       dec_halted = 1'b0;

    int fail_count = 0;
    int cycle_count = 0;
    int accepted_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cycle = 0;
    int stall_style = 0;
    int hold_left = 0;
    int next_hold_at = 40;

    uri_percent_unescaper_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .start_string (start_string),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .stop_hit     (stop_hit),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [7:0] low;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            return 5'(ch - CH_ZERO);
        low = ch | CASE_BIT;
        if (low >= CH_LOW_A && low <= CH_LOW_F)
            return 5'(low - CH_LOW_A) + HEX_LETTER;
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return CH_ZERO + 8'(nib);
        return (upper ? (CH_LOW_A & ~CASE_BIT) : CH_LOW_A) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (hex_val(ch) < 5'd16);
        return ch;
    endfunction

    function automatic logic is_safe(input logic [7:0] v);
        return v > CH_PCT && v < CH_DEL;
    endfunction

    // Runs one accepted byte through the decoder and queues the bytes it must produce.
    task automatic decode_byte(input logic [7:0] ch, input logic fresh);
        logic [4:0] hv;
        logic [7:0] v;
        logic [7:0] grp [3];
        logic       stop;
        int         n;
        n = 0;
        stop = 1'b0;
        if (fresh)
        begin
            dec_phase = PH_PLAIN;
            dec_halted = 1'b0;
        end
        if (dec_halted)
            return;
        hv = hex_val(ch);
        case (dec_phase)
            PH_QUOTED:
            begin
                if (hv < 5'd16)
                begin
                    dec_high = hv[3:0];
                    dec_first = ch;
                    dec_phase = PH_SECOND;
                end
                else
                begin
                    dec_phase = PH_PLAIN;
                    grp[0] = ch;
                    n = 1;
                end
            end
            PH_SECOND:
            begin
                dec_phase = PH_PLAIN;
                if (hv < 5'd16)
                begin
                    v = {dec_high, hv[3:0]};
                    grp[0] = v;
                    n = 1;
                    if (ch <= CH_NINE)
                    begin
                        if (cfg_mode[MODE_REDIRECT_BIT] && !is_safe(v))
                            n = 3;
                    end
                    else if (cfg_mode != 2'd0)
                    begin
                        if (v == CH_QMARK)
                        begin
                            stop = 1'b1;
                            dec_halted = 1'b1;
                        end
                        else if (!cfg_mode[MODE_URI_BIT] && !is_safe(v))
                            n = 3;
                    end
                    if (n == 3)
                    begin
                        grp[0] = CH_PCT;
                        grp[1] = dec_first;
                        grp[2] = ch;
                    end
                end
            end
            default:
            begin
                dec_phase = PH_PLAIN;
                if (ch == CH_QMARK && cfg_mode != 2'd0)
                begin
                    grp[0] = ch;
                    n = 1;
                    stop = 1'b1;
                    dec_halted = 1'b1;
                end
                else if (ch == CH_PCT)
                    dec_phase = PH_QUOTED;
                else
                begin
                    grp[0] = ch;
                    n = 1;
                end
            end
        endcase
        for (int i = 0; i < n; i++)
            decoded_bytes.push_back('{grp[i], stop, i == n - 1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= 8'h00;
            start_string <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, start_string);
                accepted_count <= accepted_count + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (escaped_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_byte <= escaped_bytes[0].data;
                    start_string <= escaped_bytes[0].fresh;
                    void'(escaped_bytes.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_cycle = stall_cycle + 1;
            if (stall_cycle % 64 == 0)
                stall_style = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (accepted_count >= next_hold_at)
            begin
                hold_left = 90;
                next_hold_at = next_hold_at + 100;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= stall_cycle[0];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_bytes.size() == 0)
            begin
                $display("%0t: unexpected item, actual out_byte %02h", $time, out_byte);
                fail_count++;
            end
            else
            begin
                if (out_byte !== decoded_bytes[0].data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, decoded_bytes[0].data, out_byte);
                    fail_count++;
                end
                if (stop_hit !== decoded_bytes[0].stop)
                begin
                    $display("%0t: stop_hit expected %0b actual %0b",
                             $time, decoded_bytes[0].stop, stop_hit);
                    fail_count++;
                end
                if (last_of_run !== decoded_bytes[0].last)
                begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, decoded_bytes[0].last, last_of_run);
                    fail_count++;
                end
                void'(decoded_bytes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_mode(input logic [1:0] mode);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_ADDR;
        pwdata <= ($urandom & ~32'h3) | 32'(mode);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_mode = mode;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (escaped_bytes.size() != 0 || in_valid || decoded_bytes.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_byte(input logic [7:0] ch, input logic fresh);
        escaped_bytes.push_back('{ch, fresh});
    endtask

    task automatic put_triplet(input logic [7:0] v);
        put_byte(CH_PCT, 1'b0);
        put_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
        put_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    // Mostly well-formed strings with random content, plus broken escapes and raw bytes.
    task automatic add_strings(input int count);
        int kind;
        while (escaped_bytes.size() < count)
        begin
            put_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b1);
            repeat ($urandom_range(2, 10))
            begin
                kind = $urandom_range(0, 11);
                if (kind <= 3)
                    put_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
                else if (kind <= 7)
                    put_triplet(($urandom_range(0, 7) == 0) ? CH_QMARK : 8'($urandom));
                else if (kind == 8)
                    put_byte(CH_QMARK, 1'b0);
                else if (kind == 9)
                begin
                    put_byte(CH_PCT, 1'b0);
                    put_byte(non_hex(), 1'b0);
                end
                else if (kind == 10)
                begin
                    put_byte(CH_PCT, 1'b0);
                    put_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))), 1'b0);
                    put_byte(non_hex(), 1'b0);
                end
                else
                    put_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(2'd2);
        put_byte(8'h00, 1'b1);
        put_byte(8'hff, 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte("4", 1'b0); put_byte("1", 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte("2", 1'b0); put_byte("0", 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte("0", 1'b0); put_byte("a", 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte(CH_PCT, 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte("4", 1'b0); put_byte("G", 1'b0);
        put_byte(CH_PCT, 1'b0); put_byte("3", 1'b0); put_byte("F", 1'b0);
        put_byte("x", 1'b0);
        put_byte("a", 1'b1);
        put_byte(CH_QMARK, 1'b0);
        put_byte(CH_PCT, 1'b1); put_byte("4", 1'b0);
        put_byte("B", 1'b1);
        wait_idle();

        write_mode(2'd0);
        add_strings(24);
        wait_idle();
        write_mode(2'd1);
        add_strings(24);
        wait_idle();
        write_mode(2'd3);
        add_strings(24);
        wait_idle();
        write_mode(2'd2);
        add_strings(24);
        wait_idle();
        write_mode(2'($urandom));
        add_strings(24);
        wait_idle();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
